[sv/i2cmts_pkg.sv]
package i2cmts_pkg;

    localparam int BUFFER_BYTES_DEFAULT = 32;
    localparam int COUNTER_BITS_DEFAULT = 16;

    // result queue depth, a power of two with room for two pushes
    localparam int OUTQ_DEPTH = 4;

    typedef struct packed {
        logic [2:0] mode;
        logic [4:0] slot;
        logic [7:0] byte_in;
        logic [1:0] transfer_kind;
        logic [7:0] target_address;
        logic [5:0] write_count;
        logic [5:0] read_count;
        logic [5:0] event_flags;
        logic [6:0] error_flags;
    } item_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  byte_out;
        logic [15:0] counter_value;
        logic        ack_enable;
        logic        buffer_irq_enable;
        logic [3:0]  bus_status;
        logic        finished;
        logic        fault;
        logic        last;
    } result_t;

endpackage

[sv/i2c_master_transaction_sequencer.sv]
// I2C master transaction sequencer, 7-bit addressing.
// The input stream carries one item per transaction: mode in s_axis_tuser picks
// a buffer load, a transfer start, a bus event, an error event or a read-back.
// The result stream carries bus commands (command in m_axis_tuser) with the
// address or data byte, the enables, status and a finished flag; m_axis_tlast
// marks the final result of each input item (an item yields one or two).
// An accepted item is registered with its buffer read, decoded once the
// result queue has room, and its results are pushed into the queue that drives
// m_axis. Throughput is one item per cycle while the queue has room; an item
// with two results pushes both at once. The rate is set by the single decode
// stage and the registered buffer read, whose address is taken from the
// incoming item and the state left by the item ahead of it.
// A four-entry result queue decouples the sides: when the receiver stalls the
// queue fills and s_axis_tready drops once fewer than two entries are free.
// Reset (aresetn low, synchronous) idles the transfer, sets ack enable, clears
// the error counters and empties the queue; the data buffer is not cleared and
// holds no defined value until written. No clearing pass is needed.
module i2c_master_transaction_sequencer #(
    parameter int BUFFER_BYTES = i2cmts_pkg::BUFFER_BYTES_DEFAULT,
    parameter int COUNTER_BITS = i2cmts_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slot, byte_in, transfer_kind, target_address, write_count, read_count,
    // event_flags, error_flags
    input  logic [47:0] s_axis_tdata,
    // mode
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // byte_out, counter_value, ack_enable, buffer_irq_enable, bus_status,
    // finished, fault
    output logic [31:0] m_axis_tdata,
    // command
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(BUFFER_BYTES);

    i2cmts_pkg::item_t   in_item;
    i2cmts_pkg::item_t   item_reg;
    logic                item_valid_reg;
    logic                rd0_ok_reg;
    logic                accept;
    logic                process;
    logic                room;

    logic [AW-1:0]       raddr0;
    logic                raddr0_ok;
    logic [7:0]          rdata0, rdata1;
    logic                buf_we;
    logic [AW-1:0]       buf_waddr;
    logic [7:0]          buf_wdata;

    i2cmts_pkg::result_t res0, res1, m_res;
    logic                res_two;

    assign in_item.mode           = s_axis_tuser;
    assign in_item.slot           = s_axis_tdata[4:0];
    assign in_item.byte_in        = s_axis_tdata[12:5];
    assign in_item.transfer_kind  = s_axis_tdata[14:13];
    assign in_item.target_address = s_axis_tdata[22:15];
    assign in_item.write_count    = s_axis_tdata[28:23];
    assign in_item.read_count     = s_axis_tdata[34:29];
    assign in_item.event_flags    = s_axis_tdata[40:35];
    assign in_item.error_flags    = s_axis_tdata[47:41];

    assign process       = item_valid_reg && room;
    assign s_axis_tready = !item_valid_reg || process;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            item_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg   <= in_item;
            rd0_ok_reg <= raddr0_ok;
        end
    end

    i2cmts_seq #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .COUNTER_BITS(COUNTER_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .process   (process),
        .item      (item_reg),
        .rd0_data  (rdata0),
        .rd0_ok    (rd0_ok_reg),
        .rd1_data  (rdata1),
        .next_mode (in_item.mode),
        .next_slot (in_item.slot),
        .raddr0    (raddr0),
        .raddr0_ok (raddr0_ok),
        .buf_we    (buf_we),
        .buf_waddr (buf_waddr),
        .buf_wdata (buf_wdata),
        .res0      (res0),
        .res1      (res1),
        .res_two   (res_two)
    );

    // second port always fetches the second buffer byte
    i2cmts_buf #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_buf (
        .aclk   (aclk),
        .we     (buf_we),
        .waddr  (buf_waddr),
        .wdata  (buf_wdata),
        .rd_en  (accept),
        .raddr0 (raddr0),
        .raddr1 (AW'(1)),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    i2cmts_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (process),
        .push_two (res_two),
        .res0     (res0),
        .res1     (res1),
        .room     (room),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_res    (m_res)
    );

    assign m_axis_tuser        = m_res.command;
    assign m_axis_tdata[7:0]   = m_res.byte_out;
    assign m_axis_tdata[23:8]  = m_res.counter_value;
    assign m_axis_tdata[24]    = m_res.ack_enable;
    assign m_axis_tdata[25]    = m_res.buffer_irq_enable;
    assign m_axis_tdata[29:26] = m_res.bus_status;
    assign m_axis_tdata[30]    = m_res.finished;
    assign m_axis_tdata[31]    = m_res.fault;
    assign m_axis_tlast        = m_res.last;

endmodule

[sv/i2cmts_buf.sv]
module i2cmts_buf #(
    parameter int BUFFER_BYTES = i2cmts_pkg::BUFFER_BYTES_DEFAULT,
    localparam int AW = $clog2(BUFFER_BYTES)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          rd_en,
    input  logic [AW-1:0] raddr0,
    input  logic [AW-1:0] raddr1,
    output logic [7:0]    rdata0,
    output logic [7:0]    rdata1
);

    logic [7:0] mem [BUFFER_BYTES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // a write in the same cycle is passed straight to the read side
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (we && waddr == raddr0) begin
                rdata0 <= wdata;
            end else begin
                rdata0 <= mem[raddr0];
            end
            if (we && waddr == raddr1) begin
                rdata1 <= wdata;
            end else begin
                rdata1 <= mem[raddr1];
            end
        end
    end

endmodule

[sv/i2cmts_outq.sv]
module i2cmts_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  logic                push_two,
    input  i2cmts_pkg::result_t res0,
    input  i2cmts_pkg::result_t res1,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output i2cmts_pkg::result_t m_res
);

    localparam int DEPTH = i2cmts_pkg::OUTQ_DEPTH;
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    i2cmts_pkg::result_t entry_reg [DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_push;
    logic          pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_res   = entry_reg[head_reg];
    assign room    = (count_reg <= CW'(DEPTH - 2));

    always_comb begin
        n_push = '0;
        if (push) begin
            n_push = push_two ? CW'(2) : CW'(1);
        end
        count_next = count_reg + n_push - (pop ? CW'(1) : CW'(0));
        tail_next  = tail_reg + PW'(n_push);
        head_next  = head_reg + (pop ? PW'(1) : PW'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end else begin
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[tail_reg] <= res0;
            if (push_two) begin
                entry_reg[PW'(tail_reg + PW'(1))] <= res1;
            end
        end
    end

endmodule

[sv/i2cmts_seq.sv]
module i2cmts_seq #(
    parameter int BUFFER_BYTES = i2cmts_pkg::BUFFER_BYTES_DEFAULT,
    parameter int COUNTER_BITS = i2cmts_pkg::COUNTER_BITS_DEFAULT,
    localparam int AW = $clog2(BUFFER_BYTES)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                process,
    input  i2cmts_pkg::item_t   item,
    input  logic [7:0]          rd0_data,
    input  logic                rd0_ok,
    input  logic [7:0]          rd1_data,
    input  logic [2:0]          next_mode,
    input  logic [4:0]          next_slot,
    output logic [AW-1:0]       raddr0,
    output logic                raddr0_ok,
    output logic                buf_we,
    output logic [AW-1:0]       buf_waddr,
    output logic [7:0]          buf_wdata,
    output i2cmts_pkg::result_t res0,
    output i2cmts_pkg::result_t res1,
    output logic                res_two
);

    localparam int NUM_COUNTERS = 7;

    typedef enum logic [3:0] {
        PH_COMPLETE  = 4'd0,
        PH_START     = 4'd1,
        PH_ADDR_WR   = 4'd2,
        PH_SENDING   = 4'd3,
        PH_STOP      = 4'd4,
        PH_ADDR_RD   = 4'd5,
        PH_READING   = 4'd6,
        PH_READ_LAST = 4'd7,
        PH_RESTART   = 4'd8,
        PH_FAILED    = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_ADDR_WR = 3'd1,
        CMD_ADDR_RD = 3'd2,
        CMD_DATA    = 3'd3,
        CMD_STOP    = 3'd4,
        CMD_START   = 3'd5,
        CMD_RESET   = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_LOAD     = 3'd0,
        MODE_START    = 3'd1,
        MODE_BUS      = 3'd2,
        MODE_ERROR    = 3'd3,
        MODE_READ_BUF = 3'd4,
        MODE_READ_CNT = 3'd5
    } mode_t;

    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_RX      = 2'd1;
    localparam logic [1:0] KIND_TX_RX   = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam int EV_SB   = 0;
    localparam int EV_ADDR = 1;
    localparam int EV_TRA  = 2;
    localparam int EV_TXE  = 3;
    localparam int EV_RXNE = 4;
    localparam int EV_BTF  = 5;
    localparam int ER_ACK_FAIL = 0;

    phase_t      phase_reg, phase_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  addr_reg, addr_next;
    logic [5:0]  wt_reg, wt_next;
    logic [5:0]  rt_reg, rt_next;
    logic [5:0]  pos_reg, pos_next;
    logic        ack_reg, ack_next;
    logic        birq_reg, birq_next;
    logic [COUNTER_BITS-1:0] cnt_reg [NUM_COUNTERS];
    logic [COUNTER_BITS-1:0] cnt_next [NUM_COUNTERS];

    cmd_t        cmd0, cmd1;
    logic [7:0]  byte0, byte1;
    logic        two;
    logic        fin, flt;
    logic [15:0] cval;
    logic        we_c;
    logic [5:0]  widx;
    logic [7:0]  rd0_val;
    logic [6:0]  pos_plus2;

    phase_t      phase_fwd;
    logic [5:0]  pos_fwd;
    logic [5:0]  ridx;

    assign rd0_val   = rd0_ok ? rd0_data : 8'd0;
    assign pos_plus2 = 7'(pos_reg) + 7'd2;

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        addr_next  = addr_reg;
        wt_next    = wt_reg;
        rt_next    = rt_reg;
        pos_next   = pos_reg;
        ack_next   = ack_reg;
        birq_next  = birq_reg;
        for (int k = 0; k < NUM_COUNTERS; k++) begin
            cnt_next[k] = cnt_reg[k];
        end
        cmd0  = CMD_NONE;
        cmd1  = CMD_NONE;
        byte0 = 8'd0;
        byte1 = 8'd0;
        two   = 1'b0;
        fin   = 1'b0;
        flt   = 1'b0;
        cval  = 16'd0;
        we_c  = 1'b0;
        widx  = pos_reg;

        case (mode_t'(item.mode))
            MODE_LOAD: begin
                widx = {1'b0, item.slot};
                we_c = 1'b1;
            end
            MODE_START: begin
                if (phase_reg != PH_COMPLETE && phase_reg != PH_FAILED) begin
                    flt = 1'b1;
                end else begin
                    kind_next  = (item.transfer_kind == KIND_UNUSED) ? KIND_TX_RX
                                                                     : item.transfer_kind;
                    addr_next  = item.target_address;
                    wt_next    = (32'(item.write_count) > BUFFER_BYTES) ? 6'(BUFFER_BYTES)
                                                                       : item.write_count;
                    rt_next    = (32'(item.read_count) > BUFFER_BYTES) ? 6'(BUFFER_BYTES)
                                                                      : item.read_count;
                    pos_next   = 6'd0;
                    phase_next = PH_START;
                    cmd0       = CMD_START;
                end
            end
            MODE_BUS: begin
                case (phase_reg)
                    PH_START: begin
                        if (!item.event_flags[EV_SB]) begin
                            flt = 1'b1;
                        end else if (kind_reg == KIND_RX) begin
                            cmd0       = CMD_ADDR_RD;
                            byte0      = addr_reg | 8'h01;
                            phase_next = PH_ADDR_RD;
                        end else begin
                            cmd0       = CMD_ADDR_WR;
                            byte0      = addr_reg & 8'hFE;
                            phase_next = PH_ADDR_WR;
                        end
                    end
                    PH_ADDR_WR: begin
                        if (!(item.event_flags[EV_ADDR] && item.event_flags[EV_TRA])) begin
                            flt = 1'b1;
                        end else begin
                            cmd0  = CMD_DATA;
                            byte0 = rd0_val;
                            two   = 1'b1;
                            if (wt_reg > 6'd1) begin
                                cmd1       = CMD_DATA;
                                byte1      = rd1_data;
                                pos_next   = 6'd2;
                                birq_next  = 1'b1;
                                phase_next = PH_SENDING;
                            end else begin
                                pos_next = 6'd1;
                                if (kind_reg == KIND_TX) begin
                                    cmd1       = CMD_STOP;
                                    phase_next = PH_STOP;
                                end else begin
                                    cmd1       = CMD_START;
                                    phase_next = PH_RESTART;
                                end
                            end
                        end
                    end
                    PH_SENDING: begin
                        if (!item.event_flags[EV_TXE]) begin
                            flt = 1'b1;
                        end else if (pos_reg < wt_reg) begin
                            cmd0     = CMD_DATA;
                            byte0    = rd0_val;
                            pos_next = pos_reg + 6'd1;
                        end else begin
                            birq_next = 1'b0;
                            if (kind_reg == KIND_TX) begin
                                cmd0       = CMD_STOP;
                                phase_next = PH_STOP;
                            end else begin
                                cmd0       = CMD_START;
                                phase_next = PH_RESTART;
                            end
                        end
                    end
                    PH_STOP: begin
                        // the final received byte may land here
                        we_c       = item.event_flags[EV_RXNE] && (pos_reg < rt_reg);
                        birq_next  = 1'b0;
                        fin        = 1'b1;
                        phase_next = PH_COMPLETE;
                    end
                    PH_ADDR_RD: begin
                        if (!(item.event_flags[EV_ADDR] && !item.event_flags[EV_TRA])) begin
                            flt = 1'b1;
                        end else begin
                            pos_next = 6'd0;
                            if (rt_reg == 6'd1) begin
                                ack_next   = 1'b0;
                                cmd0       = CMD_STOP;
                                phase_next = PH_READ_LAST;
                            end else begin
                                ack_next   = 1'b1;
                                birq_next  = 1'b1;
                                phase_next = PH_READING;
                            end
                        end
                    end
                    PH_READING: begin
                        if (!item.event_flags[EV_RXNE] || pos_reg >= rt_reg) begin
                            flt = 1'b1;
                        end else begin
                            we_c     = 1'b1;
                            pos_next = pos_reg + 6'd1;
                            if (pos_plus2 >= 7'(rt_reg)) begin
                                ack_next   = 1'b0;
                                cmd0       = CMD_STOP;
                                phase_next = PH_STOP;
                            end
                        end
                    end
                    PH_READ_LAST: begin
                        if (item.event_flags[EV_BTF]) begin
                            we_c       = 1'b1;
                            cmd0       = CMD_STOP;
                            phase_next = PH_STOP;
                        end else if (item.event_flags[EV_RXNE]) begin
                            we_c       = 1'b1;
                            phase_next = PH_STOP;
                        end else begin
                            flt = 1'b1;
                        end
                    end
                    PH_RESTART: begin
                        // events other than start sent are dropped quietly here
                        if (item.event_flags[EV_SB]) begin
                            cmd0       = CMD_ADDR_RD;
                            byte0      = addr_reg | 8'h01;
                            phase_next = PH_ADDR_RD;
                        end
                    end
                    default: begin
                        flt = 1'b1;
                    end
                endcase
            end
            MODE_ERROR: begin
                for (int k = 0; k < NUM_COUNTERS; k++) begin
                    if (item.error_flags[k]) begin
                        cnt_next[k] = cnt_reg[k] + COUNTER_BITS'(1);
                    end
                end
                if (item.error_flags[ER_ACK_FAIL]) begin
                    cmd0 = CMD_STOP;
                    cmd1 = CMD_RESET;
                    two  = 1'b1;
                end else begin
                    cmd0 = CMD_RESET;
                end
                fin        = 1'b1;
                phase_next = PH_FAILED;
                ack_next   = 1'b1;
                birq_next  = 1'b0;
            end
            MODE_READ_BUF: begin
                byte0 = rd0_val;
            end
            MODE_READ_CNT: begin
                if (32'(item.slot) < NUM_COUNTERS) begin
                    cval = 16'(cnt_reg[item.slot[2:0]]);
                end
            end
            default: begin
                flt = 1'b1;
            end
        endcase
    end

    // buffer write
    assign buf_we    = process && we_c && (32'(widx) < BUFFER_BYTES);
    assign buf_waddr = AW'(widx);
    assign buf_wdata = item.byte_in;

    // the item behind reads the buffer with the state this item leaves
    assign phase_fwd = process ? phase_next : phase_reg;
    assign pos_fwd   = process ? pos_next : pos_reg;

    always_comb begin
        if (mode_t'(next_mode) == MODE_READ_BUF) begin
            ridx = {1'b0, next_slot};
        end else if (phase_fwd == PH_ADDR_WR) begin
            ridx = 6'd0;
        end else begin
            ridx = pos_fwd;
        end
    end

    assign raddr0    = AW'(ridx);
    assign raddr0_ok = (32'(ridx) < BUFFER_BYTES);

    always_comb begin
        res0.command           = cmd0;
        res0.byte_out          = byte0;
        res0.counter_value     = cval;
        res0.ack_enable        = ack_next;
        res0.buffer_irq_enable = birq_next;
        res0.bus_status        = phase_next;
        res0.finished          = fin;
        res0.fault             = flt;
        res0.last              = !two;
        res1          = res0;
        res1.command  = cmd1;
        res1.byte_out = byte1;
        res1.last     = 1'b1;
    end

    assign res_two = two;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_COMPLETE;
            kind_reg  <= 2'd0;
            addr_reg  <= 8'd0;
            wt_reg    <= 6'd0;
            rt_reg    <= 6'd0;
            pos_reg   <= 6'd0;
            ack_reg   <= 1'b1;
            birq_reg  <= 1'b0;
            for (int k = 0; k < NUM_COUNTERS; k++) begin
                cnt_reg[k] <= '0;
            end
        end else if (process) begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
            wt_reg    <= wt_next;
            rt_reg    <= rt_next;
            pos_reg   <= pos_next;
            ack_reg   <= ack_next;
            birq_reg  <= birq_next;
            for (int k = 0; k < NUM_COUNTERS; k++) begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

endmodule

[bench/i2c_master_transaction_sequencer_tb.sv]
module i2c_master_transaction_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmts_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 130;
    localparam int CALM_AFTER = 100;

    // input modes
    localparam logic [2:0] MODE_LOAD = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_EVENT = 3'd2;
    localparam logic [2:0] MODE_ERROR = 3'd3;
    localparam logic [2:0] MODE_READ_BUF = 3'd4;
    localparam logic [2:0] MODE_READ_CNT = 3'd5;
    localparam logic [2:0] MODE_BAD_6 = 3'd6;
    localparam logic [2:0] MODE_BAD_7 = 3'd7;

    // bus commands
    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_ADDR_WR = 3'd1;
    localparam logic [2:0] CMD_ADDR_RD = 3'd2;
    localparam logic [2:0] CMD_DATA = 3'd3;
    localparam logic [2:0] CMD_STOP = 3'd4;
    localparam logic [2:0] CMD_START = 3'd5;
    localparam logic [2:0] CMD_RESET = 3'd6;

    // transfer phases
    localparam logic [3:0] PH_COMPLETE = 4'd0;
    localparam logic [3:0] PH_START = 4'd1;
    localparam logic [3:0] PH_ADDR_WR = 4'd2;
    localparam logic [3:0] PH_SENDING = 4'd3;
    localparam logic [3:0] PH_STOP = 4'd4;
    localparam logic [3:0] PH_ADDR_RD = 4'd5;
    localparam logic [3:0] PH_READING = 4'd6;
    localparam logic [3:0] PH_READ_LAST = 4'd7;
    localparam logic [3:0] PH_RESTART = 4'd8;
    localparam logic [3:0] PH_FAILED = 4'd9;

    // transfer kinds
    localparam logic [1:0] KIND_TX = 2'd0;
    localparam logic [1:0] KIND_RX = 2'd1;
    localparam logic [1:0] KIND_TX_RX = 2'd2;
    localparam logic [1:0] KIND_ODD = 2'd3;

    // event flag bit positions
    localparam int EV_SB = 0;
    localparam int EV_ADDR = 1;
    localparam int EV_TRA = 2;
    localparam int EV_TXE = 3;
    localparam int EV_RXNE = 4;
    localparam int EV_BTF = 5;

    // error flag bit positions
    localparam int ER_ACK_FAIL = 0;
    localparam int NUM_COUNTERS = 7;

    typedef struct packed {
        logic [3:0]        phase;
        logic [1:0]        kind;
        logic [7:0]        addr;
        logic [5:0]        wtot;
        logic [5:0]        rtot;
        logic [5:0]        pos;
        logic [31:0][7:0]  mem;
        logic [31:0]       known;
        logic              ack;
        logic              irq;
        logic [6:0][15:0]  errs;
    } seq_state_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    seq_state_t sequencer_state;
    result_t    pending_results[$];
    int         mismatches = 0;
    int         items_sent = 0;
    int         results_checked = 0;
    int         transfers_started = 0;
    int         transfers_ended = 0;
    int         stall_left = 0;
    bit         calm = 1'b0;
    bit         steady = 1'b0;

    i2c_master_transaction_sequencer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [7:0] fetch_byte(input seq_state_t s, input logic [5:0] idx,
                                              inout int miss);
        if (!s.known[idx[4:0]] && miss < 0) miss = int'(idx[4:0]);
        return s.mem[idx[4:0]];
    endfunction

    function automatic void store_byte(inout seq_state_t s, input logic [5:0] idx,
                                       input logic [7:0] value);
        if (idx < 6'd32) begin
            s.mem[idx[4:0]] = value;
            s.known[idx[4:0]] = 1'b1;
        end
    endfunction

    // advances the sequencer state by one item and lists the bus commands it causes;
    // miss names a buffer entry that would be read before ever being written
    function automatic void advance_sequencer(inout seq_state_t s, input item_t it,
                                              output result_t [1:0] res, output int n,
                                              output int miss);
        logic [1:0][2:0] cmd;
        logic [1:0][7:0] dat;
        logic [15:0]     cval;
        logic [5:0]      ev;
        logic            fin;
        logic            flt;
        cmd = '0;
        dat = '0;
        cval = '0;
        fin = 1'b0;
        flt = 1'b0;
        n = 0;
        miss = -1;
        res = '0;
        ev = it.event_flags;
        case (it.mode)
            MODE_LOAD: begin
                store_byte(s, {1'b0, it.slot}, it.byte_in);
            end
            MODE_START: begin
                if (s.phase != PH_COMPLETE && s.phase != PH_FAILED) begin
                    flt = 1'b1;
                end else begin
                    s.kind = (it.transfer_kind == KIND_ODD) ? KIND_TX_RX : it.transfer_kind;
                    s.addr = it.target_address;
                    s.wtot = (it.write_count > 6'd32) ? 6'd32 : it.write_count;
                    s.rtot = (it.read_count > 6'd32) ? 6'd32 : it.read_count;
                    s.pos = '0;
                    s.phase = PH_START;
                    cmd[n] = CMD_START;
                    n++;
                end
            end
            MODE_EVENT: begin
                case (s.phase)
                    PH_START: begin
                        if (!ev[EV_SB]) begin
                            flt = 1'b1;
                        end else if (s.kind == KIND_RX) begin
                            cmd[n] = CMD_ADDR_RD;
                            dat[n] = s.addr | 8'h01;
                            n++;
                            s.phase = PH_ADDR_RD;
                        end else begin
                            cmd[n] = CMD_ADDR_WR;
                            dat[n] = s.addr & 8'hFE;
                            n++;
                            s.phase = PH_ADDR_WR;
                        end
                    end
                    PH_ADDR_WR: begin
                        if (!(ev[EV_ADDR] && ev[EV_TRA])) begin
                            flt = 1'b1;
                        end else begin
                            cmd[n] = CMD_DATA;
                            dat[n] = fetch_byte(s, 6'd0, miss);
                            n++;
                            if (s.wtot > 6'd1) begin
                                cmd[n] = CMD_DATA;
                                dat[n] = fetch_byte(s, 6'd1, miss);
                                n++;
                                s.pos = 6'd2;
                                s.irq = 1'b1;
                                s.phase = PH_SENDING;
                            end else begin
                                s.pos = 6'd1;
                                cmd[n] = (s.kind == KIND_TX) ? CMD_STOP : CMD_START;
                                n++;
                                s.phase = (s.kind == KIND_TX) ? PH_STOP : PH_RESTART;
                            end
                        end
                    end
                    PH_SENDING: begin
                        if (!ev[EV_TXE]) begin
                            flt = 1'b1;
                        end else if (s.pos < s.wtot) begin
                            cmd[n] = CMD_DATA;
                            dat[n] = fetch_byte(s, s.pos, miss);
                            n++;
                            s.pos = s.pos + 6'd1;
                        end else begin
                            s.irq = 1'b0;
                            cmd[n] = (s.kind == KIND_TX) ? CMD_STOP : CMD_START;
                            n++;
                            s.phase = (s.kind == KIND_TX) ? PH_STOP : PH_RESTART;
                        end
                    end
                    PH_STOP: begin
                        if (ev[EV_RXNE] && s.pos < s.rtot) store_byte(s, s.pos, it.byte_in);
                        s.irq = 1'b0;
                        fin = 1'b1;
                        s.phase = PH_COMPLETE;
                    end
                    PH_ADDR_RD: begin
                        if (!(ev[EV_ADDR] && !ev[EV_TRA])) begin
                            flt = 1'b1;
                        end else begin
                            s.pos = '0;
                            if (s.rtot == 6'd1) begin
                                s.ack = 1'b0;
                                cmd[n] = CMD_STOP;
                                n++;
                                s.phase = PH_READ_LAST;
                            end else begin
                                s.ack = 1'b1;
                                s.irq = 1'b1;
                                s.phase = PH_READING;
                            end
                        end
                    end
                    PH_READING: begin
                        if (!ev[EV_RXNE] || s.pos >= s.rtot) begin
                            flt = 1'b1;
                        end else begin
                            store_byte(s, s.pos, it.byte_in);
                            s.pos = s.pos + 6'd1;
                            if (s.pos + 6'd1 >= s.rtot) begin
                                s.ack = 1'b0;
                                cmd[n] = CMD_STOP;
                                n++;
                                s.phase = PH_STOP;
                            end
                        end
                    end
                    PH_READ_LAST: begin
                        if (ev[EV_BTF]) begin
                            store_byte(s, s.pos, it.byte_in);
                            cmd[n] = CMD_STOP;
                            n++;
                            s.phase = PH_STOP;
                        end else if (ev[EV_RXNE]) begin
                            store_byte(s, s.pos, it.byte_in);
                            s.phase = PH_STOP;
                        end else begin
                            flt = 1'b1;
                        end
                    end
                    PH_RESTART: begin
                        // no start sent yet: quietly ignored
                        if (ev[EV_SB]) begin
                            cmd[n] = CMD_ADDR_RD;
                            dat[n] = s.addr | 8'h01;
                            n++;
                            s.phase = PH_ADDR_RD;
                        end
                    end
                    default: flt = 1'b1;
                endcase
            end
            MODE_ERROR: begin
                for (int k = 0; k < NUM_COUNTERS; k++) begin
                    if (it.error_flags[k]) s.errs[k] = s.errs[k] + 16'd1;
                end
                if (it.error_flags[ER_ACK_FAIL]) begin
                    cmd[n] = CMD_STOP;
                    n++;
                end
                fin = 1'b1;
                s.phase = PH_FAILED;
                s.ack = 1'b1;
                s.irq = 1'b0;
                cmd[n] = CMD_RESET;
                n++;
            end
            MODE_READ_BUF: begin
                cmd[n] = CMD_NONE;
                dat[n] = fetch_byte(s, {1'b0, it.slot}, miss);
                n++;
            end
            MODE_READ_CNT: begin
                if (it.slot < 5'(NUM_COUNTERS)) cval = s.errs[it.slot[2:0]];
            end
            default: flt = 1'b1;
        endcase
        if (n == 0) begin
            cmd[0] = CMD_NONE;
            dat[0] = '0;
            n = 1;
        end
        for (int k = 0; k < n; k++) begin
            res[k].command = cmd[k];
            res[k].byte_out = dat[k];
            res[k].counter_value = cval;
            res[k].ack_enable = s.ack;
            res[k].buffer_irq_enable = s.irq;
            res[k].bus_status = s.phase;
            res[k].finished = fin;
            res[k].fault = flt;
            res[k].last = (k == n - 1);
        end
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.mode = 3'($urandom_range(0, 7));
        it.slot = 5'($urandom_range(0, 31));
        it.byte_in = 8'($urandom_range(0, 255));
        it.transfer_kind = 2'($urandom_range(0, 3));
        it.target_address = 8'($urandom_range(0, 255));
        it.write_count = 6'($urandom_range(0, 63));
        it.read_count = 6'($urandom_range(0, 63));
        it.event_flags = 6'($urandom_range(0, 63));
        it.error_flags = 7'($urandom_range(0, 127));
        return it;
    endfunction

    function automatic item_t make_item(input logic [2:0] mode, input logic [4:0] slot,
                                        input logic [7:0] byte_in, input logic [1:0] kind,
                                        input logic [7:0] addr, input logic [5:0] wcnt,
                                        input logic [5:0] rcnt, input logic [5:0] ev,
                                        input logic [6:0] er);
        item_t it;
        it.mode = mode;
        it.slot = slot;
        it.byte_in = byte_in;
        it.transfer_kind = kind;
        it.target_address = addr;
        it.write_count = wcnt;
        it.read_count = rcnt;
        it.event_flags = ev;
        it.error_flags = er;
        return it;
    endfunction

    // mostly the flags the current phase waits for, over random extra bits
    function automatic logic [5:0] flags_for_phase(input logic [3:0] ph);
        logic [5:0] ev;
        ev = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 9) == 0) return ev;
        case (ph)
            PH_START: ev[EV_SB] = 1'b1;
            PH_ADDR_WR: begin
                ev[EV_ADDR] = 1'b1;
                ev[EV_TRA] = 1'b1;
            end
            PH_SENDING: ev[EV_TXE] = 1'b1;
            PH_ADDR_RD: begin
                ev[EV_ADDR] = 1'b1;
                ev[EV_TRA] = 1'b0;
            end
            PH_READING: ev[EV_RXNE] = 1'b1;
            PH_READ_LAST: begin
                if ($urandom_range(0, 1) == 0) begin
                    ev[EV_BTF] = 1'b1;
                end else begin
                    ev[EV_BTF] = 1'b0;
                    ev[EV_RXNE] = 1'b1;
                end
            end
            PH_RESTART: ev[EV_SB] = ($urandom_range(0, 5) != 0);
            default: ;
        endcase
        return ev;
    endfunction

    function automatic logic [5:0] random_count();
        if ($urandom_range(0, 7) == 0) return 6'($urandom_range(6, 63));
        return 6'($urandom_range(0, 5));
    endfunction

    task automatic send_item(input item_t it);
        result_t [1:0] res;
        int            n;
        int            miss;
        int            gap;
        if (!calm && !steady && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.mode;
        s_axis_tdata <= {it.error_flags, it.event_flags, it.read_count, it.write_count,
                         it.target_address, it.transfer_kind, it.byte_in, it.slot};
        do @(posedge aclk); while (!s_axis_tready);
        advance_sequencer(sequencer_state, it, res, n, miss);
        for (int k = 0; k < n; k++) pending_results.push_back(res[k]);
        items_sent++;
        if (it.mode == MODE_START && res[0].command == CMD_START) transfers_started++;
        if (res[0].finished) transfers_ended++;
        @(negedge aclk);
    endtask

    // fills any buffer entry the item would read before it was ever written
    task automatic send(input item_t it);
        seq_state_t    trial;
        result_t [1:0] res;
        int            n;
        int            miss;
        forever begin
            trial = sequencer_state;
            advance_sequencer(trial, it, res, n, miss);
            if (miss < 0) break;
            send_item(make_item(MODE_LOAD, 5'(miss), 8'($urandom_range(0, 255)), KIND_TX,
                                8'h00, 6'd0, 6'd0, 6'd0, 7'd0));
        end
        send_item(it);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_event(input logic [5:0] ev, input logic [7:0] rx);
        send(make_item(MODE_EVENT, 5'd0, rx, KIND_TX, 8'h00, 6'd0, 6'd0, ev, 7'd0));
    endtask

    task automatic test_idle_readbacks();
        send(make_item(MODE_READ_CNT, 5'd0, 8'h00, KIND_TX, 8'h00, 6'd0, 6'd0, 6'd0, 7'd0));
        send(make_item(MODE_READ_CNT, 5'd31, 8'hFF, KIND_ODD, 8'hFF, 6'd63, 6'd63,
                       6'd63, 7'd127));
        send(make_item(MODE_BAD_6, 5'd3, 8'h12, KIND_TX, 8'h00, 6'd0, 6'd0, 6'd0, 7'd0));
        send(make_item(MODE_BAD_7, 5'd4, 8'h34, KIND_RX, 8'h00, 6'd0, 6'd0, 6'd0, 7'd0));
        // any bus event with no transfer running is spurious
        send_event(6'h3F, 8'h55);
        drain();
    endtask

    task automatic test_write_only();
        send(make_item(MODE_LOAD, 5'd0, 8'h00, KIND_TX, 8'h00, 6'd0, 6'd0, 6'd0, 7'd0));
        send(make_item(MODE_LOAD, 5'd1, 8'hFF, KIND_TX, 8'h00, 6'd0, 6'd0, 6'd0, 7'd0));
        send(make_item(MODE_START, 5'd0, 8'h00, KIND_TX, 8'hFF, 6'd2, 6'd0, 6'd0, 7'd0));
        send_event(6'(1 << EV_SB), 8'h00);
        // start while busy is refused
        send(make_item(MODE_START, 5'd0, 8'h00, KIND_RX, 8'h10, 6'd1, 6'd1, 6'd0, 7'd0));
        send_event(6'(1 << EV_TXE), 8'h00);
        send_event(6'((1 << EV_ADDR) | (1 << EV_TRA)), 8'h00);
        send_event(6'(1 << EV_TXE), 8'h00);
        send_event(6'd0, 8'h00);
        drain();
    endtask

    task automatic test_write_then_read();
        // kind three behaves as transmit then receive, zero write count still sends
        send(make_item(MODE_START, 5'd0, 8'h00, KIND_ODD, 8'h00, 6'd0, 6'd1, 6'd0, 7'd0));
        send_event(6'(1 << EV_SB), 8'h00);
        send_event(6'((1 << EV_ADDR) | (1 << EV_TRA)), 8'h00);
        send_event(6'(1 << EV_TXE), 8'h00);
        send_event(6'(1 << EV_SB), 8'h00);
        send_event(6'(1 << EV_ADDR), 8'h00);
        send_event(6'(1 << EV_BTF), 8'hA5);
        send_event(6'(1 << EV_RXNE), 8'h5A);
        send(make_item(MODE_READ_BUF, 5'd0, 8'h00, KIND_TX, 8'h00, 6'd0, 6'd0, 6'd0, 7'd0));
        drain();
    endtask

    task automatic test_error_abort();
        send(make_item(MODE_ERROR, 5'd0, 8'h00, KIND_TX, 8'h00, 6'd0, 6'd0, 6'd0, 7'h7F));
        send(make_item(MODE_ERROR, 5'd0, 8'h00, KIND_TX, 8'h00, 6'd0, 6'd0, 6'd0, 7'h00));
        send(make_item(MODE_READ_CNT, 5'd6, 8'h00, KIND_TX, 8'h00, 6'd0, 6'd0, 6'd0, 7'd0));
        drain();
    endtask

    task automatic test_random_transfers();
        item_t it;
        int    first;
        int    steps;
        int    budget;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            calm = (items_sent - first > CALM_AFTER);
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                it = random_item();
                it.mode = ($urandom_range(0, 1) == 0) ? MODE_READ_BUF : MODE_READ_CNT;
                send(it);
            end
            it = random_item();
            it.mode = MODE_START;
            it.write_count = random_count();
            it.read_count = random_count();
            send(it);
            steps = 0;
            budget = int'(it.write_count) + int'(it.read_count) + 10;
            while (sequencer_state.phase != PH_COMPLETE &&
                   sequencer_state.phase != PH_FAILED && steps < budget) begin
                it = random_item();
                if ($urandom_range(0, 39) == 0) begin
                    it.mode = MODE_ERROR;
                end else if ($urandom_range(0, 13) != 0) begin
                    it.mode = MODE_EVENT;
                    it.event_flags = flags_for_phase(sequencer_state.phase);
                end
                send(it);
                steps++;
            end
            // stuck transfers are aborted by an error
            if (sequencer_state.phase != PH_COMPLETE && sequencer_state.phase != PH_FAILED) begin
                it = random_item();
                it.mode = MODE_ERROR;
                send(it);
            end
        end
        steady = 1'b0;
        drain();
    endtask

    task automatic report_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s) at %0t", what, $realtime);
            $display("  expected cmd %0d byte %02h cnt %04h ack %0b irq %0b st %0d fin %0b flt %0b last %0b",
                     want.command, want.byte_out, want.counter_value, want.ack_enable,
                     want.buffer_irq_enable, want.bus_status, want.finished, want.fault,
                     want.last);
            $display("  actual   cmd %0d byte %02h cnt %04h ack %0b irq %0b st %0d fin %0b flt %0b last %0b",
                     got.command, got.byte_out, got.counter_value, got.ack_enable,
                     got.buffer_irq_enable, got.bus_status, got.finished, got.fault,
                     got.last);
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.command = m_axis_tuser;
            got.byte_out = m_axis_tdata[7:0];
            got.counter_value = m_axis_tdata[23:8];
            got.ack_enable = m_axis_tdata[24];
            got.buffer_irq_enable = m_axis_tdata[25];
            got.bus_status = m_axis_tdata[29:26];
            got.finished = m_axis_tdata[30];
            got.fault = m_axis_tdata[31];
            got.last = m_axis_tlast;
            results_checked++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.command !== want.command || got.byte_out !== want.byte_out ||
                    got.counter_value !== want.counter_value ||
                    got.ack_enable !== want.ack_enable ||
                    got.buffer_irq_enable !== want.buffer_irq_enable ||
                    got.bus_status !== want.bus_status || got.finished !== want.finished ||
                    got.fault !== want.fault || got.last !== want.last)
                    report_mismatch("field differs", want, got);
            end
        end
    end

    // receiver backpressure in random bursts
    always @(negedge aclk) begin
        if (calm || steady) begin
            stall_left <= 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
                 pending_results.size());
        $display("** i2c_master_transaction_sequencer: FAILED **");
        $finish;
    end

    initial begin
        sequencer_state = '0;
        sequencer_state.ack = 1'b1;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_idle_readbacks();
        test_write_only();
        test_write_then_read();
        test_error_abort();
        test_random_transfers();
        $display("sent %0d input transactions over %0d transfers (%0d ended), checked %0d results",
                 items_sent, transfers_started, transfers_ended, results_checked);
        $display("mismatches %0d, results never seen %0d", mismatches, pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** i2c_master_transaction_sequencer: PASSED **");
        end else begin
            $display("** i2c_master_transaction_sequencer: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
sv/i2cmts_pkg.sv
sv/i2cmts_buf.sv
sv/i2cmts_outq.sv
sv/i2cmts_seq.sv
sv/i2c_master_transaction_sequencer.sv
bench/i2c_master_transaction_sequencer_tb.sv
